>>> sv/mep_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel block.
// No dependencies; compiled first.
package mep_pkg;

  localparam int unsigned COORD_BITS_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF  = 60;
  localparam int unsigned PIX_BITS_DEF   = 12;

  localparam int unsigned DEPTH_BITS  = 16;
  localparam int unsigned CSTEP_BITS  = 32;
  localparam int unsigned COLOUR_BITS = 16;
  localparam int unsigned CPROD_BITS  = DEPTH_BITS + CSTEP_BITS;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 64;

  localparam logic [CFG_IDX_BITS-1:0] REG_X_ORIGIN    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_ORIGIN    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_STEP      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_STEP      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOUR_STEP = 3'd5;

  localparam logic [DEPTH_BITS-1:0] MAX_ITER_RESET    = 16'd25;
  localparam logic [CSTEP_BITS-1:0] COLOUR_STEP_RESET = 32'd171798691;

  // Operand pairs for the shared multiplier
  typedef enum logic [2:0] {
    MSEL_CX,
    MSEL_CY,
    MSEL_XY,
    MSEL_XX,
    MSEL_YY
  } mep_msel_e;

  typedef struct packed {
    logic      pix_load;
    logic      mul_start;
    mep_msel_e mul_sel;
    logic      cx_load;
    logic      cy_load;
    logic      orbit_init;
    logic      xy_load;
    logic      upd1;
    logic      upd2;
    logic      xx_load;
    logic      yy_load;
    logic      iter_inc;
    logic      esc_set;
    logic      colour_calc;
    logic      out_load;
  } mep_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic limit_zero;
    logic iter_last;
    logic escape;
  } mep_status_t;

endpackage

>>> sv/mep_if.sv
// Handshake channels for the pixel input and the colour result.
// Depends on mep_pkg.
interface mep_pix_if #(
  parameter int unsigned PIX_BITS = mep_pkg::PIX_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [PIX_BITS-1:0] pixel_column;
  logic [PIX_BITS-1:0] pixel_row;

  modport source (output valid, output pixel_column, output pixel_row, input ready);
  modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

interface mep_res_if;
  import mep_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   escaped;
  logic [DEPTH_BITS-1:0]  escape_depth;
  logic [COLOUR_BITS-1:0] red;
  logic [COLOUR_BITS-1:0] green;
  logic [COLOUR_BITS-1:0] blue;

  modport source (output valid, output escaped, output escape_depth, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input escaped, input escape_depth, input red,
                  input green, input blue, output ready);
endinterface

>>> sv/mep_mul.sv
// Multi-cycle signed fixed-point multiplier: four half-width partial products,
// then sign fix, a floor shift when frac_i is set, and saturation. Depends on mep_pkg.
module mep_mul #(
  parameter int unsigned COORD_BITS = mep_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = mep_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         frac_i,
  input  logic signed [COORD_BITS-1:0] a_i,
  input  logic signed [COORD_BITS-1:0] b_i,
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] res_o
);
  import mep_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned H     = (C + 1) / 2;
  localparam int unsigned PP_W  = 2 * H;
  localparam int unsigned ACC_W = 2 * C;

  localparam logic [2:0] CNT_PP_LAST = 3'd3;
  localparam logic [2:0] CNT_NEG     = 3'd5;
  localparam logic [2:0] CNT_SAT     = 3'd6;

  localparam logic signed [C-1:0] MAXV = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0] MINV = {1'b1, {(C-1){1'b0}}};

  logic                     busy_q, pp_vld_q, done_q;
  logic [2:0]               cnt_q;
  logic [C-1:0]             mag_a_q, mag_b_q;
  logic                     neg_q, frac_q;
  logic [PP_W-1:0]          pp_q;
  logic [1:0]               pp_idx_q;
  logic [ACC_W-1:0]         acc_q;
  logic signed [ACC_W-1:0]  prod_q;
  logic signed [C-1:0]      res_q;

  logic [C-1:0]             mag_a, mag_b;
  logic [H-1:0]             ah, bh;
  logic [PP_W-1:0]          pp_d;
  logic [ACC_W-1:0]         pp_ext, addend;
  logic signed [ACC_W-1:0]  shd;
  logic [ACC_W-C:0]         top_bits;
  logic signed [C-1:0]      sat_d;

  assign mag_a = a_i[C-1] ? C'(-a_i) : C'(a_i);
  assign mag_b = b_i[C-1] ? C'(-b_i) : C'(b_i);

  // cnt bit 1 picks the half of a, bit 0 the half of b
  assign ah   = cnt_q[1] ? H'(mag_a_q >> H) : mag_a_q[H-1:0];
  assign bh   = cnt_q[0] ? H'(mag_b_q >> H) : mag_b_q[H-1:0];
  assign pp_d = ah * bh;

  assign pp_ext = ACC_W'(pp_q);
  always_comb begin
    case (pp_idx_q)
      2'd0:    addend = pp_ext;
      2'd1:    addend = pp_ext << H;
      2'd2:    addend = pp_ext << H;
      default: addend = pp_ext << (2 * H);
    endcase
  end

  // floor shift is an arithmetic shift of the exact product
  assign shd      = frac_q ? (prod_q >>> FRAC_BITS) : prod_q;
  assign top_bits = shd[ACC_W-1:C-1];
  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      sat_d = shd[C-1:0];
    end else begin
      sat_d = shd[ACC_W-1] ? MINV : MAXV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pp_vld_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q   <= 1'b1;
        pp_vld_q <= 1'b0;
        cnt_q    <= '0;
      end else if (busy_q) begin
        pp_vld_q <= (cnt_q <= CNT_PP_LAST);
        cnt_q    <= cnt_q + 3'd1;
        if (cnt_q == CNT_SAT) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_a_q <= mag_a;
      mag_b_q <= mag_b;
      neg_q   <= a_i[C-1] ^ b_i[C-1];
      frac_q  <= frac_i;
      acc_q   <= '0;
    end else if (busy_q) begin
      if (cnt_q <= CNT_PP_LAST) begin
        pp_q     <= pp_d;
        pp_idx_q <= cnt_q[1:0];
      end
      if (pp_vld_q) begin
        acc_q <= acc_q + addend;
      end
      if (cnt_q == CNT_NEG) begin
        prod_q <= neg_q ? -acc_q : acc_q;
      end
      if (cnt_q == CNT_SAT) begin
        res_q <= sat_d;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sv/mep_dp.sv
// Datapath: configuration registers, point mapping, orbit registers, escape test,
// colour mapping and the result register. Depends on mep_pkg and mep_mul.
module mep_dp #(
  parameter int unsigned COORD_BITS       = mep_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS        = mep_pkg::FRAC_BITS_DEF,
  parameter int unsigned PIXEL_INDEX_BITS = mep_pkg::PIX_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mep_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [mep_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic [PIXEL_INDEX_BITS-1:0]        pixel_column_i,
  input  logic [PIXEL_INDEX_BITS-1:0]        pixel_row_i,
  input  mep_pkg::mep_cmd_t                  cmd_i,
  output mep_pkg::mep_status_t               status_o,
  output logic                               escaped_o,
  output logic [mep_pkg::DEPTH_BITS-1:0]     escape_depth_o,
  output logic [mep_pkg::COLOUR_BITS-1:0]    red_o,
  output logic [mep_pkg::COLOUR_BITS-1:0]    green_o,
  output logic [mep_pkg::COLOUR_BITS-1:0]    blue_o
);
  import mep_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam logic signed [C-1:0] MAXV = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0] MINV = {1'b1, {(C-1){1'b0}}};
  localparam logic [C:0]          FOUR = (C+1)'(1) << (FRAC_BITS + 2);

  function automatic logic signed [C-1:0] sat_add(input logic signed [C-1:0] a,
                                                   input logic signed [C-1:0] b);
    logic [C:0] s;
    s = {a[C-1], a} + {b[C-1], b};
    if (s[C] != s[C-1]) begin
      sat_add = s[C] ? MINV : MAXV;
    end else begin
      sat_add = s[C-1:0];
    end
  endfunction

  // configuration
  logic signed [C-1:0]    xo_q, yo_q, xs_q, ys_q;
  logic [DEPTH_BITS-1:0]  maxit_q;
  logic [CSTEP_BITS-1:0]  cstep_q;

  // per-item state
  logic [PIXEL_INDEX_BITS-1:0] row_q;
  logic signed [C-1:0]    cx_q, cy_q, x_q, y_q, xx_q, yy_q, xy_q, t1_q, t2_q;
  logic [DEPTH_BITS-1:0]  iter_q;
  logic                   esc_q;
  logic [CPROD_BITS-1:0]  cprod_q;

  logic                   out_esc_q;
  logic [DEPTH_BITS-1:0]  out_depth_q;
  logic [COLOUR_BITS-1:0] out_red_q, out_green_q, out_blue_q;

  logic signed [C-1:0]    mul_a, mul_b, mres;
  logic                   mul_frac, mul_done;
  logic [C:0]             esc_sum;
  logic [COLOUR_BITS-1:0] red_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xo_q    <= '0;
      yo_q    <= '0;
      xs_q    <= '0;
      ys_q    <= '0;
      maxit_q <= MAX_ITER_RESET;
      cstep_q <= COLOUR_STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_ORIGIN:    xo_q    <= cfg_data_i[C-1:0];
        REG_Y_ORIGIN:    yo_q    <= cfg_data_i[C-1:0];
        REG_X_STEP:      xs_q    <= cfg_data_i[C-1:0];
        REG_Y_STEP:      ys_q    <= cfg_data_i[C-1:0];
        REG_MAX_ITER:    maxit_q <= cfg_data_i[DEPTH_BITS-1:0];
        REG_COLOUR_STEP: cstep_q <= cfg_data_i[CSTEP_BITS-1:0];
        default:         ;
      endcase
    end
  end

  // column comes straight off the input bus on the accept cycle
  always_comb begin
    mul_frac = 1'b1;
    case (cmd_i.mul_sel)
      MSEL_CX: begin
        mul_a    = C'(pixel_column_i);
        mul_b    = xs_q;
        mul_frac = 1'b0;
      end
      MSEL_CY: begin
        mul_a    = C'(row_q);
        mul_b    = ys_q;
        mul_frac = 1'b0;
      end
      MSEL_XY: begin
        mul_a = x_q;
        mul_b = y_q;
      end
      MSEL_XX: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      MSEL_YY: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = y_q;
      end
    endcase
  end

  mep_mul #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .frac_i  (mul_frac),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mres)
  );

  // squares are never negative, so the sum is taken unsigned
  assign esc_sum = {1'b0, xx_q} + {1'b0, yy_q};
  assign red_sat = (|cprod_q[CPROD_BITS-1:CSTEP_BITS]) ? {COLOUR_BITS{1'b1}}
                                                       : cprod_q[CSTEP_BITS-1:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      row_q <= pixel_row_i;
    end
    if (cmd_i.cx_load) begin
      cx_q <= sat_add(xo_q, mres);
    end
    if (cmd_i.cy_load) begin
      cy_q <= sat_add(yo_q, mres);
    end
    if (cmd_i.orbit_init) begin
      x_q    <= '0;
      y_q    <= '0;
      xx_q   <= '0;
      yy_q   <= '0;
      iter_q <= '0;
      esc_q  <= 1'b0;
    end
    if (cmd_i.xy_load) begin
      xy_q <= mres;
    end
    if (cmd_i.upd1) begin
      t1_q <= sat_add(xx_q, -yy_q);
      t2_q <= sat_add(xy_q, xy_q);
    end
    if (cmd_i.upd2) begin
      x_q <= sat_add(t1_q, cx_q);
      y_q <= sat_add(t2_q, cy_q);
    end
    if (cmd_i.xx_load) begin
      xx_q <= mres;
    end
    if (cmd_i.yy_load) begin
      yy_q <= mres;
    end
    if (cmd_i.iter_inc) begin
      iter_q <= iter_q + DEPTH_BITS'(1);
    end
    if (cmd_i.esc_set) begin
      esc_q <= 1'b1;
    end
    if (cmd_i.colour_calc) begin
      cprod_q <= iter_q * cstep_q;
    end
    if (cmd_i.out_load) begin
      out_esc_q   <= esc_q;
      out_depth_q <= esc_q ? iter_q : '0;
      out_red_q   <= esc_q ? red_sat : '0;
      out_green_q <= esc_q ? (red_sat >> 1) : '0;
      out_blue_q  <= esc_q ? ~red_sat : '0;
    end
  end

  assign status_o.mul_done   = mul_done;
  assign status_o.limit_zero = (maxit_q == '0);
  assign status_o.iter_last  = (iter_q == maxit_q - DEPTH_BITS'(1));
  assign status_o.escape     = (esc_sum > FOUR);

  assign escaped_o      = out_esc_q;
  assign escape_depth_o = out_depth_q;
  assign red_o          = out_red_q;
  assign green_o        = out_green_q;
  assign blue_o         = out_blue_q;

endmodule

>>> sv/mep_ctrl.sv
// Controller: sequences point mapping, orbit steps, escape test and result hand-off.
// Depends on mep_pkg.
module mep_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  input  mep_pkg::mep_status_t status_i,
  output mep_pkg::mep_cmd_t    cmd_o,
  output logic                 in_ready_o,
  output logic                 out_valid_o
);
  import mep_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CX_RUN,
    S_CY_RUN,
    S_XY_GO,
    S_XY_RUN,
    S_UPD1,
    S_UPD2,
    S_XX_GO,
    S_XX_RUN,
    S_YY_RUN,
    S_TEST,
    S_COLOUR,
    S_FINISH
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;
  mep_cmd_t cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.pix_load  = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_CX;
          state_d       = S_CX_RUN;
        end
      end
      S_CX_RUN: begin
        if (status_i.mul_done) begin
          cmd.cx_load   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_CY;
          state_d       = S_CY_RUN;
        end
      end
      S_CY_RUN: begin
        if (status_i.mul_done) begin
          cmd.cy_load    = 1'b1;
          cmd.orbit_init = 1'b1;
          state_d        = status_i.limit_zero ? S_FINISH : S_XY_GO;
        end
      end
      S_XY_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_XY;
        state_d       = S_XY_RUN;
      end
      S_XY_RUN: begin
        if (status_i.mul_done) begin
          cmd.xy_load = 1'b1;
          state_d     = S_UPD1;
        end
      end
      S_UPD1: begin
        cmd.upd1 = 1'b1;
        state_d  = S_UPD2;
      end
      S_UPD2: begin
        cmd.upd2 = 1'b1;
        state_d  = S_XX_GO;
      end
      S_XX_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_XX;
        state_d       = S_XX_RUN;
      end
      S_XX_RUN: begin
        if (status_i.mul_done) begin
          cmd.xx_load   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_YY;
          state_d       = S_YY_RUN;
        end
      end
      S_YY_RUN: begin
        if (status_i.mul_done) begin
          cmd.yy_load = 1'b1;
          state_d     = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.escape) begin
          cmd.esc_set = 1'b1;
          state_d     = S_COLOUR;
        end else if (status_i.iter_last) begin
          state_d = S_FINISH;
        end else begin
          // next step starts right away from the current x, y
          cmd.iter_inc  = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_XY;
          state_d       = S_XY_RUN;
        end
      end
      S_COLOUR: begin
        cmd.colour_calc = 1'b1;
        state_d         = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule

>>> sv/mandelbrot_escape_pixel.sv
// Top level of the Mandelbrot escape-time pixel evaluator.
// Depends on mep_pkg, mep_if, mep_mul, mep_dp and mep_ctrl.
//
//   channel   direction  payload                                     handshake
//   pix_i     in         pixel_column, pixel_row                     valid/ready
//   res_o     out        escaped, escape_depth, red, green, blue     valid/ready
//   cfg       in         cfg_idx_i, cfg_data_i                       cfg_we_i
//
// One item at a time. The orbit runs escape step + 1 steps, or max_iterations
// for an inside point, and each step makes three passes through the shared
// multiplier (x*y, x'^2, y'^2). Reset clears the configuration to its defaults
// and the controller to idle. A finished result waits in the output register
// while the next item is accepted; a stalled result holds the controller in its
// final state until the register frees.
module mandelbrot_escape_pixel #(
  parameter int unsigned COORD_BITS       = mep_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS        = mep_pkg::FRAC_BITS_DEF,
  parameter int unsigned PIXEL_INDEX_BITS = mep_pkg::PIX_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mep_pix_if.sink                           pix_i,
  mep_res_if.source                         res_o,
  input  logic                              cfg_we_i,
  input  logic [mep_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [mep_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import mep_pkg::*;

  mep_cmd_t    cmd;
  mep_status_t status;

  mep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid)
  );

  // only the low PIXEL_INDEX_BITS of each index are used
  mep_dp #(
    .COORD_BITS       (COORD_BITS),
    .FRAC_BITS        (FRAC_BITS),
    .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_column_i (PIXEL_INDEX_BITS'(pix_i.pixel_column)),
    .pixel_row_i    (PIXEL_INDEX_BITS'(pix_i.pixel_row)),
    .cmd_i          (cmd),
    .status_o       (status),
    .escaped_o      (res_o.escaped),
    .escape_depth_o (res_o.escape_depth),
    .red_o          (res_o.red),
    .green_o        (res_o.green),
    .blue_o         (res_o.blue)
  );

endmodule
